FILE: sv/activation_function_unit_macros.svh
// ----------------------------------------------------------------------------
// activation_function_unit_macros
// Assertion helpers shared by the activation function unit RTL.
// ----------------------------------------------------------------------------
`ifndef ACTIVATION_FUNCTION_UNIT_MACROS_SVH
`define ACTIVATION_FUNCTION_UNIT_MACROS_SVH

// same-cycle implication, clocked on clock, off during reset
`define AFU_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on clock, off during reset
`define AFU_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/afu_pkg.sv
// ----------------------------------------------------------------------------
// afu_pkg
// Opcodes and default sizes of the activation function unit.
// ----------------------------------------------------------------------------
package afu_pkg;

   localparam int DATA_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF  = 12;
   localparam int OPCODE_WIDTH   = 3;

   typedef enum logic [OPCODE_WIDTH-1:0] {
      OP_SIGMOID   = 3'd0,
      OP_TANH      = 3'd1,
      OP_RELU      = 3'd2,
      OP_IDENT     = 3'd3,
      OP_SIGMOID_D = 3'd4,
      OP_TANH_D    = 3'd5,
      OP_RELU_D    = 3'd6,
      OP_IDENT_D   = 3'd7
   } opcode_type;

endpackage

FILE: sv/afu_plan.sv
// ----------------------------------------------------------------------------
// afu_plan
// Piecewise-linear sigmoid on a signed fixed-point input, result in [0, 1].
// ----------------------------------------------------------------------------
module afu_plan #(
   parameter int DATA_WIDTH = afu_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = afu_pkg::FRAC_BITS_DEF
) (
   input  logic signed [DATA_WIDTH:0] x_i,
   output logic        [FRAC_BITS:0]  y_o
);

   localparam int SW = ((DATA_WIDTH + 5) > (FRAC_BITS + 7)) ? DATA_WIDTH + 5 : FRAC_BITS + 7;

   localparam logic [SW-1:0] ONE_S   = SW'(1) << FRAC_BITS;
   localparam logic [SW-1:0] BRK_HI  = SW'(5) << FRAC_BITS;
   localparam logic [SW-1:0] BRK_MID = SW'(19) << FRAC_BITS;
   localparam logic [SW-1:0] OFS_HI  = (SW'(27) << FRAC_BITS) >> 5;
   localparam logic [SW-1:0] OFS_MID = (SW'(5) << FRAC_BITS) >> 3;
   localparam logic [SW-1:0] OFS_LO  = ONE_S >> 1;

   logic                 neg;
   logic [DATA_WIDTH+1:0] x_neg;
   logic [SW-1:0]         mag;
   logic [SW-1:0]         y_seg;
   logic [FRAC_BITS:0]    y_pos;

   assign neg   = x_i[DATA_WIDTH];
   assign x_neg = -{x_i[DATA_WIDTH], x_i};
   assign mag   = neg ? SW'(x_neg[DATA_WIDTH:0]) : SW'(x_i[DATA_WIDTH:0]);

   always_comb begin
      if (mag >= BRK_HI) begin
         y_seg = ONE_S;
      end else if ((mag << 3) >= BRK_MID) begin
         y_seg = (mag >> 5) + OFS_HI;
      end else if (mag >= ONE_S) begin
         y_seg = (mag >> 3) + OFS_MID;
      end else begin
         y_seg = (mag >> 2) + OFS_LO;
      end
   end

   assign y_pos = y_seg[FRAC_BITS:0];
   assign y_o   = neg ? ONE_S[FRAC_BITS:0] - y_pos : y_pos;

endmodule

FILE: sv/afu_calc.sv
// ----------------------------------------------------------------------------
// afu_calc
// Activation datapath: sigmoid, tanh, relu, identity and their derivatives.
// ----------------------------------------------------------------------------
module afu_calc #(
   parameter int DATA_WIDTH = afu_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = afu_pkg::FRAC_BITS_DEF
) (
   input  logic [afu_pkg::OPCODE_WIDTH-1:0] opcode_i,
   input  logic signed [DATA_WIDTH-1:0]     operand_i,
   output logic [DATA_WIDTH-1:0]            value_o
);

   localparam int MW = ((DATA_WIDTH > FRAC_BITS + 2) ? DATA_WIDTH : FRAC_BITS + 2) + 1;
   localparam int PW = DATA_WIDTH + MW;
   localparam int RW = PW + 1;

   localparam logic signed [MW-1:0] ONE_M = $signed(MW'(1) << FRAC_BITS);
   localparam logic signed [RW-1:0] ONE_R = $signed(RW'(1) << FRAC_BITS);
   localparam logic signed [RW-1:0] VMAX  = $signed((RW'(1) << (DATA_WIDTH - 1)) - RW'(1));
   localparam logic signed [RW-1:0] VMIN  = ~VMAX;

   afu_pkg::opcode_type        op;
   logic signed [DATA_WIDTH:0] x_one;
   logic signed [DATA_WIDTH:0] x_two;
   logic [FRAC_BITS:0]         sig_y;
   logic [FRAC_BITS:0]         dbl_y;
   logic signed [MW-1:0]       x_m;
   logic signed [MW-1:0]       mul_b;
   logic signed [PW-1:0]       prod;
   logic signed [PW-1:0]       prod_sh;
   logic signed [RW-1:0]       res;

   assign op    = afu_pkg::opcode_type'(opcode_i);
   assign x_one = {operand_i[DATA_WIDTH-1], operand_i};
   assign x_two = {operand_i, 1'b0};

   afu_plan #(
      .DATA_WIDTH(DATA_WIDTH),
      .FRAC_BITS (FRAC_BITS)
   ) u_sig (
      .x_i(x_one),
      .y_o(sig_y)
   );

   afu_plan #(
      .DATA_WIDTH(DATA_WIDTH),
      .FRAC_BITS (FRAC_BITS)
   ) u_dbl (
      .x_i(x_two),
      .y_o(dbl_y)
   );

   assign x_m     = MW'(operand_i);
   assign mul_b   = (op == afu_pkg::OP_TANH_D) ? x_m : ONE_M - x_m;
   assign prod    = PW'(operand_i) * PW'(mul_b);
   assign prod_sh = prod >>> FRAC_BITS;

   always_comb begin
      case (op)
         afu_pkg::OP_SIGMOID:   res = $signed(RW'(sig_y));
         afu_pkg::OP_TANH:      res = $signed(RW'(dbl_y) << 1) - ONE_R;
         afu_pkg::OP_RELU:      res = (operand_i > 0) ? RW'(operand_i) : '0;
         afu_pkg::OP_IDENT:     res = RW'(operand_i);
         afu_pkg::OP_SIGMOID_D: res = RW'(prod_sh);
         afu_pkg::OP_TANH_D:    res = ONE_R - RW'(prod_sh);
         afu_pkg::OP_RELU_D:    res = (operand_i > 0) ? ONE_R : '0;
         default:               res = ONE_R;
      endcase
   end

   always_comb begin
      if (res > VMAX) begin
         value_o = VMAX[DATA_WIDTH-1:0];
      end else if (res < VMIN) begin
         value_o = VMIN[DATA_WIDTH-1:0];
      end else begin
         value_o = res[DATA_WIDTH-1:0];
      end
   end

endmodule

FILE: sv/activation_function_unit.sv
// ----------------------------------------------------------------------------
// activation_function_unit
// Path: an accepted request is held in the input reg, then its result is registered in the result reg (rsp_tvalid).
// Throughput: one request per cycle while rsp_tready is high; set by the single-pass datapath.
// Stalls: rsp_tready low holds both stages; req_tready drops once both are full.
// Reset: clears both stage valid flags; a request held in either stage is dropped.
// ----------------------------------------------------------------------------
`include "activation_function_unit_macros.svh"

module activation_function_unit #(
   parameter int DATA_WIDTH = afu_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = afu_pkg::FRAC_BITS_DEF,
   localparam int TDW       = ((DATA_WIDTH + 7) / 8) * 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [TDW-1:0]                   req_tdata,  // operand
   input  logic [afu_pkg::OPCODE_WIDTH-1:0] req_tuser,  // opcode
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [TDW-1:0]                   rsp_tdata   // value_out
);

   logic                     in_vld_ff, in_vld_in;
   afu_pkg::opcode_type      in_op_ff, in_op_in;
   logic [DATA_WIDTH-1:0]    in_dat_ff, in_dat_in;
   logic                     out_vld_ff, out_vld_in;
   logic [DATA_WIDTH-1:0]    out_dat_ff, out_dat_in;
   logic                     req_fire;
   logic                     out_open;
   logic                     in_adv;
   logic [DATA_WIDTH-1:0]    calc_value;

   assign out_open   = !out_vld_ff || rsp_tready;
   assign in_adv     = in_vld_ff && out_open;
   assign req_tready = !in_vld_ff || out_open;
   assign req_fire   = req_tvalid && req_tready;

   afu_calc #(
      .DATA_WIDTH(DATA_WIDTH),
      .FRAC_BITS (FRAC_BITS)
   ) u_calc (
      .opcode_i (in_op_ff),
      .operand_i($signed(in_dat_ff)),
      .value_o  (calc_value)
   );

   always_comb begin
      in_vld_in  = in_vld_ff;
      in_op_in   = in_op_ff;
      in_dat_in  = in_dat_ff;
      out_vld_in = out_vld_ff;
      out_dat_in = out_dat_ff;
      if (in_adv) begin
         in_vld_in = 1'b0;
      end
      if (req_fire) begin
         in_vld_in = 1'b1;
         in_op_in  = afu_pkg::opcode_type'(req_tuser);
         in_dat_in = req_tdata[DATA_WIDTH-1:0];
      end
      if (out_open) begin
         out_vld_in = in_vld_ff;
         out_dat_in = calc_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
      in_op_ff   <= in_op_in;
      in_dat_ff  <= in_dat_in;
      out_dat_ff <= out_dat_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = TDW'(out_dat_ff);

   `AFU_ASSERT_NEXT(a_adv_result, in_adv,
      out_vld_ff && out_dat_ff == $past(calc_value),
      "advanced request did not land in result register")
   `AFU_ASSERT_NEXT(a_stage_hold, in_vld_ff && !out_open,
      in_vld_ff && $stable(in_op_ff) && $stable(in_dat_ff),
      "stalled input stage changed")
   `AFU_ASSERT_NOW(a_no_drop, req_fire && in_vld_ff, in_adv,
      "input stage overwritten while occupied")
   `AFU_ASSERT_NEXT(a_relu_sign, in_adv && in_op_ff == afu_pkg::OP_RELU,
      !out_dat_ff[DATA_WIDTH-1], "relu result negative")

endmodule
